/* hdl/stxdf_pkg.sv */
// Shared types and constants for the STX/ETX report deframer.
`default_nettype none

package stxdf_pkg;

  localparam logic [7:0] FRAME_START = 8'h02;
  localparam logic [7:0] FRAME_TYPE  = 8'h40;
  localparam logic [7:0] FRAME_END   = 8'h03;

  localparam int unsigned POS_W      = 9;
  localparam int unsigned HEADER_LEN = 4;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned OUT_USER_W = 3;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_GOOD    = 2'd1,
    EV_BAD_END = 2'd2,
    EV_REJECT  = 2'd3
  } frame_event_t;

  // Frame tracking state carried from one word to the next.
  typedef struct packed {
    logic [POS_W-1:0] byte_count;
    logic [7:0]       length_held;
    logic [7:0]       running_sum;
    logic [7:0]       status_held;
    logic [7:0]       number_held;
    logic [1:0]       start_type_ok;
    logic             sum_matched;
  } frame_state_t;

  // One result word.
  typedef struct packed {
    frame_event_t frame_event;
    logic [7:0]   receiver_status;
    logic [7:0]   transmission_number;
    logic [7:0]   frame_length;
    logic         payload_valid;
    logic [7:0]   payload_byte;
    logic [7:0]   payload_index;
  } frame_result_t;

endpackage

`default_nettype wire

/* hdl/stxdf_step.sv */
// Per-word frame tracking: next state and result for one received byte.
`default_nettype none

module stxdf_step
  import stxdf_pkg::*;
(
  input  frame_state_t  state,
  input  logic [7:0]    byte_in,
  output frame_state_t  state_next,
  output frame_result_t result
);

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] data_end;
  logic [POS_W-1:0] data_offset;
  logic [7:0]       sum_add;

  assign pos         = state.byte_count;
  assign data_end    = {1'b0, state.length_held} + POS_W'(HEADER_LEN);
  assign data_offset = pos - POS_W'(HEADER_LEN);
  assign sum_add     = state.running_sum + byte_in;

  always_comb begin
    state_next           = state;
    result.frame_event   = EV_NONE;
    result.payload_valid = 1'b0;
    result.payload_byte  = 8'h00;
    result.payload_index = 8'h00;

    if (pos == POS_W'(0)) begin
      // Start position: clear everything held from the last frame.
      state_next.running_sum   = 8'h00;
      state_next.status_held   = 8'h00;
      state_next.number_held   = 8'h00;
      state_next.length_held   = 8'h00;
      state_next.sum_matched   = 1'b0;
      state_next.start_type_ok = (byte_in == FRAME_START) ? 2'b01 : 2'b00;
      state_next.byte_count    = POS_W'(1);
    end else if (pos == POS_W'(1)) begin
      state_next.status_held = byte_in;
      state_next.running_sum = sum_add;
      state_next.byte_count  = POS_W'(2);
    end else if (pos == POS_W'(2)) begin
      if (byte_in == FRAME_TYPE) begin
        state_next.start_type_ok = state.start_type_ok | 2'b10;
      end
      state_next.running_sum = sum_add;
      state_next.byte_count  = POS_W'(3);
    end else if (pos == POS_W'(3)) begin
      state_next.length_held = byte_in;
      state_next.running_sum = sum_add;
      if (state.start_type_ok != 2'b11) begin
        // Drop the header and hunt for a new start.
        result.frame_event    = EV_REJECT;
        state_next.byte_count = POS_W'(0);
      end else begin
        state_next.byte_count = POS_W'(4);
      end
    end else if (pos < data_end) begin
      result.payload_valid = 1'b1;
      result.payload_byte  = byte_in;
      result.payload_index = data_offset[7:0];
      if (pos == POS_W'(HEADER_LEN)) begin
        state_next.number_held = byte_in;
      end
      state_next.running_sum = sum_add;
      state_next.byte_count  = pos + POS_W'(1);
    end else if (pos == data_end) begin
      state_next.sum_matched = (byte_in == state.running_sum);
      state_next.byte_count  = pos + POS_W'(1);
    end else begin
      // End position (anything beyond it is treated the same way).
      result.frame_event    = (state.sum_matched && byte_in == FRAME_END) ?
                              EV_GOOD : EV_BAD_END;
      state_next.byte_count = POS_W'(0);
    end

    result.receiver_status     = state_next.status_held;
    result.transmission_number = state_next.number_held;
    result.frame_length        = state_next.length_held;
  end

endmodule

`default_nettype wire

/* hdl/stx_etx_report_deframer_core.sv */
// Top level of the STX/ETX report deframer.
`default_nettype none

// Deframer for byte streams framed as STX 0x02, status, type 0x40, length L,
// L data bytes, checksum, ETX 0x03. Every received byte produces exactly one
// result word. A word carries the frame event (none, good end, bad checksum or
// end byte, header rejected), the held status, transmission number (first
// data byte) and length of the current frame, and, for data bytes, the byte
// itself with its offset in the data region. The checksum is the 8-bit sum of
// status through the last data byte. A bad start or type byte is detected on
// the fourth byte, which is reported as header rejected; the next byte is
// then taken as a new start. Throughput is one byte per clock unless the
// result side stalls: a byte is held in the input register, is processed by
// the frame tracking logic and lands in the output register, which presents
// the result word. Both registers advance together whenever the output register
// is empty or being drained, so back-pressure on the result side stalls the
// input side only once both registers are full. There is no configuration.
module stx_etx_report_deframer_core
  import stxdf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] byte_in
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] receiver_status, [15:8] transmission_number, [23:16] frame_length,
  // [31:24] payload_byte, [39:32] payload_index
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [1:0] frame_event, [2] payload_valid
  output logic [OUT_USER_W-1:0] m_axis_tuser
);

  logic          in_vld;
  logic [7:0]    in_byte;
  logic          out_vld;
  frame_result_t out_res;
  frame_state_t  state;
  frame_state_t  state_next;
  frame_result_t step_res;
  logic          out_free;
  logic          advance;

  // Output register can take a word when empty or being read this cycle.
  assign out_free      = !out_vld || m_axis_tready;
  assign advance       = in_vld && out_free;
  assign s_axis_tready = !in_vld || out_free;

  stxdf_step u_step (
    .state      (state),
    .byte_in    (in_byte),
    .state_next (state_next),
    .result     (step_res)
  );

  // Input register: hold the byte until the tracking stage consumes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  // Frame state: advance only when a word moves into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {out_res.payload_index, out_res.payload_byte,
                          out_res.frame_length, out_res.transmission_number,
                          out_res.receiver_status};
  assign m_axis_tuser  = {out_res.payload_valid, out_res.frame_event};

endmodule

`default_nettype wire

/* hdl/stxdf_checker.sv */
// Port-level checks for the STX/ETX report deframer, bound to the top level.
`default_nettype none

module stxdf_checker
  import stxdf_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [OUT_USER_W-1:0] m_axis_tuser
);

  logic unused_in;
  assign unused_in = s_axis_tvalid ^ s_axis_tready ^ (^s_axis_tdata);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // Data bytes never coincide with a frame event.
  a_payload_no_event: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == EV_NONE)
    else $error("frame event on a data byte");

  // Outside the data region the byte and offset read as zero.
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tdata[39:24] == 16'h0000)
    else $error("payload fields set outside data region");

endmodule

bind stx_etx_report_deframer_core stxdf_checker u_stxdf_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
